>>> design/tcs_pkg.sv
package tcs_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_CC_DEBOUNCE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_RP_DEBOUNCE = 1'b1;

  localparam int unsigned DebW = 20;
  localparam logic [DebW-1:0] CC_DEBOUNCE_RESET = 20'd100000;
  localparam logic [DebW-1:0] RP_DEBOUNCE_RESET = 20'd10000;

  localparam int unsigned TimeW = 64;

  // Attach state codes as they appear on the result channel
  localparam logic [1:0] ATTACH_UNATTACHED = 2'd0;
  localparam logic [1:0] ATTACH_WAIT       = 2'd1;
  localparam logic [1:0] ATTACH_ATTACHED   = 2'd2;

  // Rp current codes
  localparam logic [1:0] RP_NONE = 2'd0;

  // Classification of the CC pair while waiting for attach
  typedef enum logic [1:0] {
    CLS_UNSET    = 2'd0,
    CLS_NONE     = 2'd1,
    CLS_ATTACHED = 2'd2,
    CLS_DEBUG    = 2'd3
  } pair_class_e;

  typedef struct packed {
    logic [2:0]       cc1_level;
    logic [2:0]       cc2_level;
    logic             vbus_present;
    logic [TimeW-1:0] now_us;
  } sample_t;

  typedef struct packed {
    logic [1:0] attach_state;
    logic       cc_polarity;
    logic       alt_supply_on;
    logic [1:0] power_report;
    logic       poll_request;
  } result_t;

  typedef struct packed {
    logic [DebW-1:0] cc_debounce_us;
    logic [DebW-1:0] rp_change_debounce_us;
  } cfg_t;

  // Decoded view of the two CC pins
  typedef struct packed {
    logic        polarity;
    logic        any_rp;
    logic [1:0]  active_rp;
    pair_class_e pair_class;
  } pin_info_t;

endpackage

>>> design/tcs_sample_if.sv
interface tcs_sample_if;
  logic                     valid;
  logic                     ready;
  logic [2:0]               cc1_level;
  logic [2:0]               cc2_level;
  logic                     vbus_present;
  logic [tcs_pkg::TimeW-1:0] now_us;

  modport source (output valid, output cc1_level, output cc2_level,
                  output vbus_present, output now_us, input ready);
  modport sink   (input valid, input cc1_level, input cc2_level,
                  input vbus_present, input now_us, output ready);
endinterface

>>> design/tcs_result_if.sv
interface tcs_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] attach_state;
  logic       cc_polarity;
  logic       alt_supply_on;
  logic [1:0] power_report;
  logic       poll_request;

  modport source (output valid, output attach_state, output cc_polarity,
                  output alt_supply_on, output power_report, output poll_request,
                  input ready);
  modport sink   (input valid, input attach_state, input cc_polarity,
                  input alt_supply_on, input power_report, input poll_request,
                  output ready);
endinterface

>>> design/tcs_cc_decode.sv
module tcs_cc_decode (
  input  logic [2:0]         cc1_level_i,
  input  logic [2:0]         cc2_level_i,
  output tcs_pkg::pin_info_t info_o
);

  logic [1:0] rp1;
  logic [1:0] rp2;
  logic       pol;

  // Rp current code of a pin: 1..3 for Rp levels, none for everything else.
  function automatic logic [1:0] rp_code(input logic [2:0] level);
    logic [1:0] code;
    case (level)
      3'd3:    code = 2'd1;
      3'd4:    code = 2'd2;
      3'd5:    code = 2'd3;
      default: code = tcs_pkg::RP_NONE;
    endcase
    return code;
  endfunction

  assign rp1 = rp_code(cc1_level_i);
  assign rp2 = rp_code(cc2_level_i);

  // CC1 is taken as active only when it sits strictly above CC2.
  assign pol = (cc1_level_i > cc2_level_i) ? 1'b0 : 1'b1;

  // Pair class: both pins Rp is a debug accessory, one pin Rp is a normal attach.
  always_comb begin
    info_o.polarity  = pol;
    info_o.active_rp = pol ? rp2 : rp1;
    info_o.any_rp    = (rp1 != tcs_pkg::RP_NONE) || (rp2 != tcs_pkg::RP_NONE);
    if ((rp1 != tcs_pkg::RP_NONE) && (rp2 != tcs_pkg::RP_NONE)) begin
      info_o.pair_class = tcs_pkg::CLS_DEBUG;
    end else if (info_o.any_rp) begin
      info_o.pair_class = tcs_pkg::CLS_ATTACHED;
    end else begin
      info_o.pair_class = tcs_pkg::CLS_NONE;
    end
  end

endmodule

>>> design/tcs_fsm.sv
module tcs_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  tcs_pkg::sample_t   sample_i,
  input  tcs_pkg::cfg_t      cfg_i,
  output tcs_pkg::result_t   result_o
);

  typedef enum logic [1:0] {
    ST_UNATTACHED = 2'd0,
    ST_WAIT       = 2'd1,
    ST_ATTACHED   = 2'd2
  } state_e;

  tcs_pkg::pin_info_t info;

  state_e                    state_q, state_d;
  tcs_pkg::pair_class_e      class_q, class_d;
  logic [1:0]                rp_level_q, rp_level_d;
  logic [tcs_pkg::TimeW-1:0] deadline_q, deadline_d;
  logic                      armed_q, armed_d;
  logic                      alt_q, alt_d;
  logic [1:0]                report;
  tcs_pkg::result_t          result_q, result_d;

  logic [tcs_pkg::DebW-1:0]  deb_sel;
  logic [tcs_pkg::TimeW:0]   sum;
  logic [tcs_pkg::TimeW-1:0] deadline_new;
  logic                      expired;

  tcs_cc_decode u_decode (
    .cc1_level_i (sample_i.cc1_level),
    .cc2_level_i (sample_i.cc2_level),
    .info_o      (info)
  );

  // One saturating adder serves both debounce deadlines.
  assign deb_sel = (state_q == ST_ATTACHED) ? cfg_i.rp_change_debounce_us
                                            : cfg_i.cc_debounce_us;
  assign sum = {1'b0, sample_i.now_us} + {{(tcs_pkg::TimeW + 1 - tcs_pkg::DebW){1'b0}}, deb_sel};
  assign deadline_new = sum[tcs_pkg::TimeW] ? {tcs_pkg::TimeW{1'b1}}
                                            : sum[tcs_pkg::TimeW-1:0];
  assign expired = (sample_i.now_us >= deadline_q);

  // Next state for one sample beat.
  always_comb begin
    state_d    = state_q;
    class_d    = class_q;
    rp_level_d = rp_level_q;
    deadline_d = deadline_q;
    armed_d    = armed_q;
    alt_d      = alt_q;
    report     = tcs_pkg::RP_NONE;
    unique case (state_q)
      ST_WAIT: begin
        if (info.pair_class != class_q) begin
          deadline_d = deadline_new;
          class_d    = info.pair_class;
        end else if (expired) begin
          if (sample_i.vbus_present && (info.pair_class == tcs_pkg::CLS_ATTACHED)) begin
            state_d    = ST_ATTACHED;
            report     = info.active_rp;
            deadline_d = '0;
            armed_d    = 1'b0;
            alt_d      = 1'b1;
          end else begin
            state_d = ST_UNATTACHED;
          end
        end
      end
      ST_ATTACHED: begin
        if (!sample_i.vbus_present) begin
          alt_d   = 1'b0;
          state_d = ST_UNATTACHED;
        end else if (info.active_rp != rp_level_q) begin
          rp_level_d = info.active_rp;
          deadline_d = deadline_new;
          armed_d    = 1'b1;
        end else if (armed_q && expired) begin
          armed_d    = 1'b0;
          deadline_d = '0;
          report     = info.active_rp;
        end
      end
      default: begin
        state_d = ST_UNATTACHED;
        if (info.any_rp) begin
          state_d = ST_WAIT;
          class_d = tcs_pkg::CLS_UNSET;
        end
      end
    endcase
  end

  // Result fields reflect the state after the step.
  always_comb begin
    result_d.attach_state  = 2'(state_d);
    result_d.cc_polarity   = info.polarity;
    result_d.alt_supply_on = alt_d;
    result_d.power_report  = report;
    result_d.poll_request  = (state_d == ST_WAIT);
  end

  // Machine state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_UNATTACHED;
      class_q    <= tcs_pkg::CLS_UNSET;
      rp_level_q <= tcs_pkg::RP_NONE;
      deadline_q <= '0;
      armed_q    <= 1'b0;
      alt_q      <= 1'b0;
      result_q   <= '0;
    end else if (step_i) begin
      state_q    <= state_d;
      class_q    <= class_d;
      rp_level_q <= rp_level_d;
      deadline_q <= deadline_d;
      armed_q    <= armed_d;
      alt_q      <= alt_d;
      result_q   <= result_d;
    end
  end

  assign result_o = result_q;

  // The supply enable follows the attached state exactly.
  a_alt_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alt_q == (state_q == ST_ATTACHED))
    else $error("alternate supply enable disagrees with attached state");

  // Attach is only reached through the wait state.
  a_no_direct_attach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (state_q == ST_UNATTACHED)) |=> (state_q != ST_ATTACHED))
    else $error("attached reached directly from unattached");

  // A current report is only ever given while attached.
  a_report_attached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_q.power_report != tcs_pkg::RP_NONE) |->
      (result_q.attach_state == tcs_pkg::ATTACH_ATTACHED))
    else $error("power report outside attached state");

  // State only moves on a sample beat.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(state_q) && $stable(deadline_q)))
    else $error("state changed without a sample beat");

endmodule

>>> design/typec_sink_attach_fsm_unit.sv
// USB Type-C sink attach machine. Each sample beat (CC1/CC2 terminations, VBUS
// presence and the current time in microseconds) runs one step of the
// Unattached / AttachWait / Attached machine and yields exactly one result beat.
// A beat enters an input register; the step is evaluated from it once the result
// register is free and written there with the machine state, so one beat is taken
// every clock cycle while the result channel does not stall; the state update
// (64-bit saturating add and compare) limits the rate. The user must write the
// two debounce times through the configuration port only while no beat is in
// flight; the block does not enforce this. The reset values are 100000 us and 10000 us.
module typec_sink_attach_fsm_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tcs_sample_if.sink                     sample_i,
  tcs_result_if.source                   result_o,
  input  logic                           cfg_we_i,
  input  logic [tcs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tcs_pkg::DebW-1:0]       cfg_data_i
);

  logic             in_valid_q;
  tcs_pkg::sample_t in_data_q;
  logic             out_valid_q;
  logic             out_free;
  logic             step;
  tcs_pkg::cfg_t    cfg_q;
  tcs_pkg::result_t result;

  // Handshake: the result register frees when empty or being drained.
  assign out_free       = !out_valid_q || result_o.ready;
  assign step           = in_valid_q && out_free;
  assign sample_i.ready = !in_valid_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      in_data_q.cc1_level    <= sample_i.cc1_level;
      in_data_q.cc2_level    <= sample_i.cc2_level;
      in_data_q.vbus_present <= sample_i.vbus_present;
      in_data_q.now_us       <= sample_i.now_us;
    end
  end

  // Result valid tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cc_debounce_us        <= tcs_pkg::CC_DEBOUNCE_RESET;
      cfg_q.rp_change_debounce_us <= tcs_pkg::RP_DEBOUNCE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcs_pkg::CFG_CC_DEBOUNCE: cfg_q.cc_debounce_us        <= cfg_data_i;
        tcs_pkg::CFG_RP_DEBOUNCE: cfg_q.rp_change_debounce_us <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcs_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (in_data_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  assign result_o.valid         = out_valid_q;
  assign result_o.attach_state  = result.attach_state;
  assign result_o.cc_polarity   = result.cc_polarity;
  assign result_o.alt_supply_on = result.alt_supply_on;
  assign result_o.power_report  = result.power_report;
  assign result_o.poll_request  = result.poll_request;

endmodule
